[sv/bpc_pkg.sv]
`default_nettype none

package bpc_pkg;

    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_PRESS_TICKS = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SETTLE_TICKS     = 1'b1;

    localparam logic [15:0] LONG_PRESS_TICKS_RESET = 16'd2000;
    localparam logic [7:0]  SETTLE_TICKS_RESET     = 8'd30;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_LONG  = 2'd2;

    typedef struct packed {
        logic action;
        logic button_level;
    } in_item_t;

    typedef struct packed {
        logic       led_on;
        logic [1:0] press_kind;
        logic       press_event;
        logic       is_held;
    } out_item_t;

endpackage

`default_nettype wire

[sv/bpc_core.sv]
`default_nettype none

module bpc_core #(
    parameter int HOLD_WIDTH   = 16,
    parameter int SETTLE_WIDTH = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire bpc_pkg::in_item_t   item,
    input  wire logic [15:0]         long_press_ticks,
    input  wire logic [7:0]          settle_ticks,
    output bpc_pkg::out_item_t       result
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PRESS,
        MODE_RELEASE
    } mode_t;

    localparam int HCW = (HOLD_WIDTH > 16) ? HOLD_WIDTH : 16;
    localparam int SCW = (SETTLE_WIDTH > 8) ? SETTLE_WIDTH : 8;
    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;
    localparam logic [SCW-1:0] SETTLE_MAX = SCW'((64'd1 << SETTLE_WIDTH) - 64'd1);

    logic                    prev_level_reg, prev_level_next;
    mode_t                   mode_reg, mode_next;
    logic [SETTLE_WIDTH-1:0] settle_reg, settle_next;
    logic                    held_reg, held_next;
    logic [HOLD_WIDTH-1:0]   hold_reg, hold_next;
    logic                    led_reg, led_next;
    logic [1:0]              kind_reg, kind_next;
    logic                    event_flag;

    logic [HOLD_WIDTH-1:0]   hold_inc;
    logic [SCW-1:0]          settle_wide;
    logic [SETTLE_WIDTH-1:0] settle_load;

    assign hold_inc = (held_reg && hold_reg != HOLD_MAX) ? HOLD_WIDTH'(hold_reg + 1'b1)
                                                         : hold_reg;

    // clamp the register to what the settle counter can hold
    assign settle_wide = SCW'(settle_ticks);
    assign settle_load = (settle_wide > SETTLE_MAX) ? SETTLE_MAX[SETTLE_WIDTH-1:0]
                                                    : settle_wide[SETTLE_WIDTH-1:0];

    always_comb
    begin
        prev_level_next = prev_level_reg;
        mode_next       = mode_reg;
        settle_next     = settle_reg;
        held_next       = held_reg;
        hold_next       = hold_reg;
        led_next        = led_reg;
        kind_next       = kind_reg;
        event_flag      = 1'b0;

        if (item.action == bpc_pkg::ACT_CLEAR)
        begin
            kind_next = bpc_pkg::KIND_NONE;
        end
        else
        begin
            hold_next = hold_inc;
            if (mode_reg != MODE_IDLE)
            begin
                if (settle_reg != '0)
                begin
                    settle_next = SETTLE_WIDTH'(settle_reg - 1'b1);
                end
                else
                begin
                    if (mode_reg == MODE_PRESS && item.button_level == bpc_pkg::LEVEL_PRESSED)
                    begin
                        held_next = 1'b1;
                        hold_next = '0;
                    end
                    else if (mode_reg == MODE_RELEASE &&
                             item.button_level == bpc_pkg::LEVEL_RELEASED && held_reg)
                    begin
                        held_next  = 1'b0;
                        led_next   = ~led_reg;
                        kind_next  = (HCW'(hold_inc) >= HCW'(long_press_ticks))
                                     ? bpc_pkg::KIND_LONG : bpc_pkg::KIND_SHORT;
                        event_flag = 1'b1;
                    end
                    mode_next = MODE_IDLE;
                end
            end
            else
            begin
                if (prev_level_reg == bpc_pkg::LEVEL_RELEASED &&
                    item.button_level == bpc_pkg::LEVEL_PRESSED)
                begin
                    mode_next   = MODE_PRESS;
                    settle_next = settle_load;
                end
                else if (prev_level_reg == bpc_pkg::LEVEL_PRESSED &&
                         item.button_level == bpc_pkg::LEVEL_RELEASED)
                begin
                    mode_next   = MODE_RELEASE;
                    settle_next = settle_load;
                end
                prev_level_next = item.button_level;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= bpc_pkg::LEVEL_RELEASED;
            mode_reg       <= MODE_IDLE;
            settle_reg     <= '0;
            held_reg       <= 1'b0;
            hold_reg       <= '0;
            led_reg        <= 1'b0;
            kind_reg       <= bpc_pkg::KIND_NONE;
        end
        else if (step)
        begin
            prev_level_reg <= prev_level_next;
            mode_reg       <= mode_next;
            settle_reg     <= settle_next;
            held_reg       <= held_next;
            hold_reg       <= hold_next;
            led_reg        <= led_next;
            kind_reg       <= kind_next;
        end
    end

    assign result.led_on      = led_next;
    assign result.press_kind  = kind_next;
    assign result.press_event = event_flag;
    assign result.is_held     = held_next;

endmodule

`default_nettype wire

[sv/button_press_classifier_top.sv]
`default_nettype none

// Debounced push button with short / long press classification. Each item is
// either a sample of the active-low button pin or a clear of the latched press
// type, and each item gives exactly one result: LED level, latched press kind,
// a press event flag and the held flag. One item is taken every clock cycle
// unless out_ready stalls the pipe; an item sits in the input register while
// the debounce state is updated in a single step, then its result waits in
// the output register until out_ready. The output register lets a new item
// enter while a finished result waits. Configuration (long press threshold,
// settle length) is written through cfg_wr_en / cfg_index / cfg_data; the
// user must write it only while no item is in flight, unenforced by the block.
module button_press_classifier_top #(
    parameter int HOLD_WIDTH   = 16,
    parameter int SETTLE_WIDTH = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire bpc_pkg::in_item_t                       in_item,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output bpc_pkg::out_item_t                           out_item,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [bpc_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

    logic               stage_valid_reg;
    bpc_pkg::in_item_t  stage_item_reg;
    logic               out_valid_reg;
    bpc_pkg::out_item_t out_item_reg;
    logic [15:0]        long_press_reg;
    logic [7:0]         settle_reg;
    logic               advance;
    bpc_pkg::out_item_t core_result;

    // item moves from input register to output register
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            long_press_reg  <= bpc_pkg::LONG_PRESS_TICKS_RESET;
            settle_reg      <= bpc_pkg::SETTLE_TICKS_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    bpc_pkg::CFG_LONG_PRESS_TICKS: long_press_reg <= cfg_data[15:0];
                    bpc_pkg::CFG_SETTLE_TICKS:     settle_reg     <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= core_result;
        end
    end

    bpc_core #(
        .HOLD_WIDTH   (HOLD_WIDTH),
        .SETTLE_WIDTH (SETTLE_WIDTH)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .item             (stage_item_reg),
        .long_press_ticks (long_press_reg),
        .settle_ticks     (settle_reg),
        .result           (core_result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item did not reach the output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> in_ready)
        else $error("input blocked with an empty input register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.press_event) |->
            (out_item.press_kind == bpc_pkg::KIND_SHORT ||
             out_item.press_kind == bpc_pkg::KIND_LONG))
        else $error("press event without a press kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.press_event) |-> !out_item.is_held)
        else $error("press event while still held");
`endif

endmodule

`default_nettype wire
